[src/fm_audio_channel_model_macros.svh]
// Assertion macros shared by the FM audio channel model RTL
`ifndef FM_AUDIO_CHANNEL_MODEL_MACROS_SVH
`define FM_AUDIO_CHANNEL_MODEL_MACROS_SVH

// same-cycle implication, disabled during reset
`define FMAC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define FMAC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/fmac_pkg.sv]
// Package: constants, types, microcode and cosine table of the FM audio channel model
`default_nettype none

package fmac_pkg;

	localparam int SAMPLE_BITS = 16;
	localparam int VAL_BITS    = 24;
	localparam int COEF_BITS   = 28;
	localparam int PROD_BITS   = COEF_BITS + VAL_BITS;
	localparam int ACC_BITS    = 56;
	localparam int SHIFT_IN    = 21 - SAMPLE_BITS;
	localparam int ECHO_DEPTH  = 480;
	localparam int ECHO_AW     = $clog2(ECHO_DEPTH);
	localparam int COS_BITS    = 10;
	localparam int QUARTER     = 1 << (COS_BITS - 2);
	localparam int COS_W       = 17;
	localparam int MIX_MIN     = 895;
	localparam int PC_BITS     = 6;
	localparam logic [PC_BITS-1:0] UC_LAST = 6'd33;
	localparam logic [14:0] DEV_RESET = 15'd31130;
	localparam logic [16:0] GAIN_UNITY = 17'd32768;

	localparam longint ONE30      = 64'sd1073741824;
	localparam longint HALFPI_Q30 = 64'sd1686629713;

	// Taylor series denominators (2k-1)*2k, k = 7 down to 1
	localparam longint TAY_D7 = 64'sd182;
	localparam longint TAY_D6 = 64'sd132;
	localparam longint TAY_D5 = 64'sd90;
	localparam longint TAY_D4 = 64'sd56;
	localparam longint TAY_D3 = 64'sd30;
	localparam longint TAY_D2 = 64'sd12;
	localparam longint TAY_D1 = 64'sd2;

	// filter coefficients, Q2.22 (pre-emphasis numerator Q6.22)
	localparam logic signed [COEF_BITS-1:0] PRE_B0 = 28'sd107798174;
	localparam logic signed [COEF_BITS-1:0] PRE_B1 = -28'sd103642500;
	localparam logic signed [COEF_BITS-1:0] PRE_NA1 = 28'sd38630;
	localparam logic signed [COEF_BITS-1:0] DE_B0 = 28'sd80846;
	localparam logic signed [COEF_BITS-1:0] DE_NA1 = 28'sd4032611;
	localparam logic signed [COEF_BITS-1:0] HP_B0 = 28'sd4079437;
	localparam logic signed [COEF_BITS-1:0] HP_B1 = -28'sd8158874;
	localparam logic signed [COEF_BITS-1:0] HP_B2 = 28'sd4079437;
	localparam logic signed [COEF_BITS-1:0] HP_NA1 = 28'sd8155729;
	localparam logic signed [COEF_BITS-1:0] HP_NA2 = -28'sd3967717;
	localparam logic signed [COEF_BITS-1:0] LP_B0 = 28'sd125638;
	localparam logic signed [COEF_BITS-1:0] LP_B1 = 28'sd251276;
	localparam logic signed [COEF_BITS-1:0] LP_B2 = 28'sd125638;
	localparam logic signed [COEF_BITS-1:0] LP_NA1 = 28'sd6099530;
	localparam logic signed [COEF_BITS-1:0] LP_NA2 = -28'sd2407777;

	// register indexes
	typedef enum logic [2:0] {
		REG_ENABLE = 3'd0,
		REG_DEV    = 3'd1,
		REG_BP     = 3'd2,
		REG_NOISE  = 3'd3,
		REG_EDELAY = 3'd4,
		REG_EGAIN  = 3'd5,
		REG_STEP   = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic        enable;
		logic [14:0] dev_limit;
		logic        bp_en;
		logic        noise_en;
		logic [8:0]  echo_delay;
		logic [15:0] echo_gain;
		logic [31:0] phase_step;
	} cfg_t;

	typedef struct packed {
		logic chain;
		logic echo;
	} clr_t;

	// microcode fields
	typedef enum logic [2:0] {
		K_MAC, K_WB, K_CLIP, K_NOISE, K_EWR, K_PHASE, K_COS, K_END
	} kind_t;
	typedef enum logic [2:0] {G_ALL, G_NOISE, G_BP, G_ECHO, G_MIX} grp_t;
	typedef enum logic [1:0] {A_CONST, A_GAIN, A_COS} asel_t;
	typedef enum logic [2:0] {B_X, B_PLI, B_PLO, B_CUR, B_DLI, B_DLO, B_Y, B_TAP} bsel_t;
	typedef enum logic [2:0] {ADD_NONE, ADD_HS0, ADD_HS1, ADD_LS0, ADD_LS1, ADD_CUR} add_t;
	typedef enum logic [3:0] {
		D_PRE, D_DE, D_HPY, D_HPN1, D_HPN2, D_LPY, D_LPN1, D_LPN2, D_CUR
	} dst_t;

	typedef struct packed {
		kind_t                         kind;
		grp_t                          grp;
		asel_t                         asel;
		bsel_t                         bsel;
		add_t                          addsel;
		logic                          clr;
		logic                          sh15;
		dst_t                          dst;
		logic signed [COEF_BITS-1:0]   coef;
	} uop_t;

	// control from the sequencer to the shared multiply-accumulate unit
	typedef struct packed {
		logic mul_en;
		logic acc_en;
		logic clr;
		logic sh15;
	} mac_ctl_t;

	function automatic uop_t mk(kind_t k, grp_t g, asel_t a, bsel_t b, add_t d,
			logic c, logic s, dst_t w, logic signed [COEF_BITS-1:0] f);
		uop_t u;
		u.kind = k;
		u.grp = g;
		u.asel = a;
		u.bsel = b;
		u.addsel = d;
		u.clr = c;
		u.sh15 = s;
		u.dst = w;
		u.coef = f;
		return u;
	endfunction

	// microprogram of one item
	function automatic uop_t uop(logic [PC_BITS-1:0] pc);
		uop_t u;
		case (pc)
			// pre-emphasis
			6'd0: u = mk(K_MAC, G_ALL, A_CONST, B_X, ADD_NONE, 1'b1, 1'b0, D_CUR, PRE_B0);
			6'd1: u = mk(K_MAC, G_ALL, A_CONST, B_PLI, ADD_NONE, 1'b0, 1'b0, D_CUR, PRE_B1);
			6'd2: u = mk(K_MAC, G_ALL, A_CONST, B_PLO, ADD_NONE, 1'b0, 1'b0, D_CUR, PRE_NA1);
			6'd3: u = mk(K_WB, G_ALL, A_CONST, B_X, ADD_NONE, 1'b0, 1'b0, D_PRE, '0);
			6'd4: u = mk(K_CLIP, G_ALL, A_CONST, B_X, ADD_NONE, 1'b0, 1'b0, D_CUR, '0);
			6'd5: u = mk(K_NOISE, G_NOISE, A_CONST, B_X, ADD_NONE, 1'b0, 1'b0, D_CUR, '0);
			// de-emphasis
			6'd6: u = mk(K_MAC, G_ALL, A_CONST, B_CUR, ADD_NONE, 1'b1, 1'b0, D_CUR, DE_B0);
			6'd7: u = mk(K_MAC, G_ALL, A_CONST, B_DLI, ADD_NONE, 1'b0, 1'b0, D_CUR, DE_B0);
			6'd8: u = mk(K_MAC, G_ALL, A_CONST, B_DLO, ADD_NONE, 1'b0, 1'b0, D_CUR, DE_NA1);
			6'd9: u = mk(K_WB, G_ALL, A_CONST, B_X, ADD_NONE, 1'b0, 1'b0, D_DE, '0);
			// high-pass biquad
			6'd10: u = mk(K_MAC, G_BP, A_CONST, B_CUR, ADD_HS0, 1'b1, 1'b0, D_CUR, HP_B0);
			6'd11: u = mk(K_WB, G_BP, A_CONST, B_X, ADD_NONE, 1'b0, 1'b0, D_HPY, '0);
			6'd12: u = mk(K_MAC, G_BP, A_CONST, B_CUR, ADD_HS1, 1'b1, 1'b0, D_CUR, HP_B1);
			6'd13: u = mk(K_MAC, G_BP, A_CONST, B_Y, ADD_NONE, 1'b0, 1'b0, D_CUR, HP_NA1);
			6'd14: u = mk(K_WB, G_BP, A_CONST, B_X, ADD_NONE, 1'b0, 1'b0, D_HPN1, '0);
			6'd15: u = mk(K_MAC, G_BP, A_CONST, B_CUR, ADD_NONE, 1'b1, 1'b0, D_CUR, HP_B2);
			6'd16: u = mk(K_MAC, G_BP, A_CONST, B_Y, ADD_NONE, 1'b0, 1'b0, D_CUR, HP_NA2);
			6'd17: u = mk(K_WB, G_BP, A_CONST, B_X, ADD_NONE, 1'b0, 1'b0, D_HPN2, '0);
			// low-pass biquad
			6'd18: u = mk(K_MAC, G_BP, A_CONST, B_CUR, ADD_LS0, 1'b1, 1'b0, D_CUR, LP_B0);
			6'd19: u = mk(K_WB, G_BP, A_CONST, B_X, ADD_NONE, 1'b0, 1'b0, D_LPY, '0);
			6'd20: u = mk(K_MAC, G_BP, A_CONST, B_CUR, ADD_LS1, 1'b1, 1'b0, D_CUR, LP_B1);
			6'd21: u = mk(K_MAC, G_BP, A_CONST, B_Y, ADD_NONE, 1'b0, 1'b0, D_CUR, LP_NA1);
			6'd22: u = mk(K_WB, G_BP, A_CONST, B_X, ADD_NONE, 1'b0, 1'b0, D_LPN1, '0);
			6'd23: u = mk(K_MAC, G_BP, A_CONST, B_CUR, ADD_NONE, 1'b1, 1'b0, D_CUR, LP_B2);
			6'd24: u = mk(K_MAC, G_BP, A_CONST, B_Y, ADD_NONE, 1'b0, 1'b0, D_CUR, LP_NA2);
			6'd25: u = mk(K_WB, G_BP, A_CONST, B_X, ADD_NONE, 1'b0, 1'b0, D_LPN2, '0);
			// echo
			6'd26: u = mk(K_EWR, G_ECHO, A_CONST, B_X, ADD_NONE, 1'b0, 1'b0, D_CUR, '0);
			6'd27: u = mk(K_MAC, G_ECHO, A_GAIN, B_TAP, ADD_CUR, 1'b1, 1'b1, D_CUR, '0);
			6'd28: u = mk(K_WB, G_ECHO, A_CONST, B_X, ADD_NONE, 1'b0, 1'b1, D_CUR, '0);
			// carrier offset mix
			6'd29: u = mk(K_PHASE, G_MIX, A_CONST, B_X, ADD_NONE, 1'b0, 1'b0, D_CUR, '0);
			6'd30: u = mk(K_COS, G_MIX, A_CONST, B_X, ADD_NONE, 1'b0, 1'b0, D_CUR, '0);
			6'd31: u = mk(K_MAC, G_MIX, A_COS, B_CUR, ADD_NONE, 1'b1, 1'b1, D_CUR, '0);
			6'd32: u = mk(K_WB, G_MIX, A_CONST, B_X, ADD_NONE, 1'b0, 1'b1, D_CUR, '0);
			default: u = mk(K_END, G_ALL, A_CONST, B_X, ADD_NONE, 1'b0, 1'b0, D_CUR, '0);
		endcase
		return u;
	endfunction

	// cosine of a folded angle m/QUARTER quarter turns, Taylor series in Q2.30
	function automatic logic signed [COS_W-1:0] cos_quarter(int m);
		longint x;
		longint x2;
		longint t;
		x = (longint'(m) * HALFPI_Q30) / QUARTER;
		x2 = x * x / ONE30;
		t = ONE30;
		t = ONE30 - (x2 * t / ONE30) / TAY_D7;
		t = ONE30 - (x2 * t / ONE30) / TAY_D6;
		t = ONE30 - (x2 * t / ONE30) / TAY_D5;
		t = ONE30 - (x2 * t / ONE30) / TAY_D4;
		t = ONE30 - (x2 * t / ONE30) / TAY_D3;
		t = ONE30 - (x2 * t / ONE30) / TAY_D2;
		t = ONE30 - (x2 * t / ONE30) / TAY_D1;
		return COS_W'((t + 64'sd16384) >>> 15);
	endfunction

	typedef logic signed [COS_W-1:0] cos_tab_t [QUARTER];

	function automatic cos_tab_t cos_table();
		cos_tab_t tab;
		for (int i = 0; i < QUARTER; i++)
			tab[i] = cos_quarter(i);
		return tab;
	endfunction

	localparam cos_tab_t COS_TAB = cos_table();
	localparam logic signed [COS_W-1:0] COS_EDGE = cos_quarter(QUARTER);

endpackage

`default_nettype wire

[src/fmac_cfg.sv]
// APB register file of the FM audio channel model
`default_nettype none

module fmac_cfg (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [4:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready,
	output fmac_pkg::cfg_t       cfg,
	output fmac_pkg::clr_t       clr
);

	fmac_pkg::cfg_t     cfg_q;
	fmac_pkg::reg_idx_t idx;
	logic               wr;

	assign pready = 1'b1;
	assign wr = psel && penable && pwrite;
	assign idx = fmac_pkg::reg_idx_t'(paddr[4:2]);
	assign cfg = cfg_q;

	// clear requests take effect at the write edge
	always_comb begin
		clr.chain = wr && (idx == fmac_pkg::REG_ENABLE) && pwdata[0];
		clr.echo = clr.chain || (wr && (idx == fmac_pkg::REG_EDELAY) && (pwdata[8:0] != 9'd0));
	end

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enable <= 1'b0;
			cfg_q.dev_limit <= fmac_pkg::DEV_RESET;
			cfg_q.bp_en <= 1'b1;
			cfg_q.noise_en <= 1'b0;
			cfg_q.echo_delay <= '0;
			cfg_q.echo_gain <= '0;
			cfg_q.phase_step <= '0;
		end else if (wr) begin
			unique case (idx)
				fmac_pkg::REG_ENABLE: cfg_q.enable <= pwdata[0];
				fmac_pkg::REG_DEV:    cfg_q.dev_limit <= pwdata[14:0];
				fmac_pkg::REG_BP:     cfg_q.bp_en <= pwdata[0];
				fmac_pkg::REG_NOISE:  cfg_q.noise_en <= pwdata[0];
				fmac_pkg::REG_EDELAY: cfg_q.echo_delay <= pwdata[8:0];
				fmac_pkg::REG_EGAIN:  cfg_q.echo_gain <= pwdata[15:0];
				fmac_pkg::REG_STEP:   cfg_q.phase_step <= pwdata;
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		unique case (idx)
			fmac_pkg::REG_ENABLE: prdata = {31'b0, cfg_q.enable};
			fmac_pkg::REG_DEV:    prdata = {17'b0, cfg_q.dev_limit};
			fmac_pkg::REG_BP:     prdata = {31'b0, cfg_q.bp_en};
			fmac_pkg::REG_NOISE:  prdata = {31'b0, cfg_q.noise_en};
			fmac_pkg::REG_EDELAY: prdata = {23'b0, cfg_q.echo_delay};
			fmac_pkg::REG_EGAIN:  prdata = {16'b0, cfg_q.echo_gain};
			fmac_pkg::REG_STEP:   prdata = cfg_q.phase_step;
			default:              prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

[src/fmac_mac.sv]
// Shared multiply-accumulate unit with rounding shift and 24-bit saturation
`default_nettype none

module fmac_mac (
	input  logic                                    clk,
	input  fmac_pkg::mac_ctl_t                      ctl,
	input  logic signed [fmac_pkg::COEF_BITS-1:0]   a,
	input  logic signed [fmac_pkg::VAL_BITS-1:0]    b,
	input  logic signed [fmac_pkg::ACC_BITS-1:0]    addend,
	output logic signed [fmac_pkg::VAL_BITS-1:0]    res
);

	localparam logic signed [fmac_pkg::ACC_BITS-1:0] VMAX =
		fmac_pkg::ACC_BITS'((64'sd1 <<< (fmac_pkg::VAL_BITS - 1)) - 64'sd1);
	localparam logic signed [fmac_pkg::ACC_BITS-1:0] VMIN = -VMAX - 1;

	logic signed [fmac_pkg::PROD_BITS-1:0] prod_q;
	logic signed [fmac_pkg::ACC_BITS-1:0]  acc_q;
	logic signed [fmac_pkg::ACC_BITS-1:0]  prod_x;
	logic signed [fmac_pkg::ACC_BITS-1:0]  rsum;
	logic signed [fmac_pkg::ACC_BITS-1:0]  rsh;

	assign prod_x = fmac_pkg::ACC_BITS'(prod_q);

	// multiply, then accumulate on the next cycle
	always_ff @(posedge clk) begin
		if (ctl.mul_en)
			prod_q <= a * b;
		if (ctl.acc_en)
			acc_q <= (ctl.clr ? addend : acc_q) + prod_x;
	end

	// round half up, shift by 15 or 22, saturate to Q4.20
	always_comb begin
		rsum = acc_q + (ctl.sh15 ? fmac_pkg::ACC_BITS'(64'sd16384)
			: fmac_pkg::ACC_BITS'(64'sd2097152));
		rsh = ctl.sh15 ? (rsum >>> 15) : (rsum >>> 22);
		if (rsh > VMAX)
			res = VMAX[fmac_pkg::VAL_BITS-1:0];
		else if (rsh < VMIN)
			res = VMIN[fmac_pkg::VAL_BITS-1:0];
		else
			res = rsh[fmac_pkg::VAL_BITS-1:0];
	end

endmodule

`default_nettype wire

[src/fmac_echo.sv]
// Echo delay line: sample memory, write pointer and fill count
`default_nettype none

module fmac_echo (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  clr,
	input  logic                                  rd_en,
	input  logic                                  wr_en,
	input  logic [8:0]                            delay,
	input  logic signed [fmac_pkg::VAL_BITS-1:0]  wdata,
	output logic signed [fmac_pkg::VAL_BITS-1:0]  tap
);

	localparam int AW = fmac_pkg::ECHO_AW;
	localparam logic [AW-1:0] LAST = AW'(fmac_pkg::ECHO_DEPTH - 1);
	localparam logic [AW:0]   DEPTH = (AW + 1)'(fmac_pkg::ECHO_DEPTH);

	logic signed [fmac_pkg::VAL_BITS-1:0] mem_q [fmac_pkg::ECHO_DEPTH];
	logic signed [fmac_pkg::VAL_BITS-1:0] rdata_q;
	logic [AW-1:0] wi_q;
	logic [AW:0]   fill_q;
	logic          rvalid_q;
	logic [AW:0]   ra_wide;
	logic [AW-1:0] ra;

	// read address trails the write pointer by the delay, modulo depth
	always_comb begin
		if ({1'b0, wi_q} >= (AW + 1)'(delay))
			ra_wide = {1'b0, wi_q} - (AW + 1)'(delay);
		else
			ra_wide = {1'b0, wi_q} + DEPTH - (AW + 1)'(delay);
		ra = ra_wide[AW-1:0];
	end

	// memory port
	always_ff @(posedge clk) begin
		if (wr_en)
			mem_q[wi_q] <= wdata;
		if (rd_en)
			rdata_q <= mem_q[ra];
	end

	// pointer, fill count; entries past the fill read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wi_q <= '0;
			fill_q <= '0;
			rvalid_q <= 1'b0;
		end else if (clr) begin
			wi_q <= '0;
			fill_q <= '0;
			rvalid_q <= 1'b0;
		end else begin
			if (rd_en)
				rvalid_q <= fill_q >= (AW + 1)'(delay);
			if (wr_en) begin
				wi_q <= (wi_q == LAST) ? '0 : wi_q + 1'b1;
				if (fill_q != DEPTH)
					fill_q <= fill_q + 1'b1;
			end
		end
	end

	assign tap = rvalid_q ? rdata_q : '0;

endmodule

`default_nettype wire

[src/fm_audio_channel_model.sv]
// Top level of the FM audio channel model: sequencer, channel state and ports
//
//  channel | signals                               | accepted when
//  --------+---------------------------------------+------------------------------
//  input   | in_valid in_ready sample_in noise_... | in_valid && in_ready
//  output  | out_valid out_ready sample_out        | out_valid && out_ready
//  config  | psel penable pwrite paddr pwdata ...  | psel && penable && pwrite
//
// An enabled item runs a 34-step microprogram on one shared multiplier: a multiply
// step passes through the execute and accumulate states, every other step (skipped
// ones too) through the execute state only; then the done state loads the output
// register and the idle state takes the next item.
// A pass-through item (channel disabled) goes from the idle state straight to done.
// in_ready is high only while the sequencer is idle; a result waiting in the output
// register holds the sequencer in its done state until taken.
// Reset clears control and channel state at once, not the data registers; the echo line is tracked by a fill count.
`default_nettype none
`include "fm_audio_channel_model_macros.svh"

module fm_audio_channel_model (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [15:0] sample_in,
	input  logic signed [15:0] noise_sample,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] sample_out
);

	localparam int VB = fmac_pkg::VAL_BITS;
	localparam int SB = fmac_pkg::SAMPLE_BITS;
	localparam int AB = fmac_pkg::ACC_BITS;
	localparam int CB = fmac_pkg::COS_BITS;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_EXEC = 4'b0010,
		S_ACC  = 4'b0100,
		S_DONE = 4'b1000
	} state_t;

	fmac_pkg::cfg_t     cfg;
	fmac_pkg::clr_t     clr;
	fmac_pkg::uop_t     u;
	fmac_pkg::mac_ctl_t mctl;

	state_t                        state_q;
	logic [fmac_pkg::PC_BITS-1:0]  pc_q;
	logic                          pass_q;
	logic signed [SB-1:0]          x_q, ns_q, pli_q, nl_q;
	logic signed [VB-1:0]          plo_q, dli_q, dlo_q, hs0_q, hs1_q, ls0_q, ls1_q;
	logic signed [VB-1:0]          cur_q, y_q;
	logic [31:0]                   phase_q;
	logic signed [fmac_pkg::COS_W-1:0] cos_q;
	logic                          out_valid_q;
	logic signed [SB-1:0]          out_q;

	logic                          accept, grp_on, run, echo_on, mix_on, out_load;
	logic signed [fmac_pkg::COEF_BITS-1:0] mac_a;
	logic signed [VB-1:0]          mac_b, mac_res, tap;
	logic signed [AB-1:0]          addend;
	logic [16:0]                   gain_sat;
	logic signed [VB-1:0]          lim, clip_v;
	logic signed [SB:0]            ndiff;
	logic signed [VB:0]            nsum;
	logic signed [VB-1:0]          noise_v;
	logic [CB-1:0]                 cidx;
	logic [CB-2:0]                 cm;
	logic signed [fmac_pkg::COS_W-1:0] cval;
	logic signed [VB:0]            oround;
	logic signed [VB-5:0]          oshift;
	logic signed [SB-1:0]          out_v;

	fmac_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg),
		.clr     (clr)
	);

	assign u = fmac_pkg::uop(pc_q);
	assign in_ready = (state_q == S_IDLE);
	assign accept = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign sample_out = out_q;

	// stage enables
	assign echo_on = (cfg.echo_delay != 9'd0) && (cfg.echo_delay < 9'(fmac_pkg::ECHO_DEPTH));
	assign mix_on = ($signed(cfg.phase_step) > 32'(fmac_pkg::MIX_MIN))
		|| ($signed(cfg.phase_step) < -32'(fmac_pkg::MIX_MIN));

	always_comb begin
		case (u.grp)
			fmac_pkg::G_ALL:   grp_on = 1'b1;
			fmac_pkg::G_NOISE: grp_on = cfg.noise_en;
			fmac_pkg::G_BP:    grp_on = cfg.bp_en;
			fmac_pkg::G_ECHO:  grp_on = echo_on;
			fmac_pkg::G_MIX:   grp_on = mix_on;
			default:           grp_on = 1'b0;
		endcase
	end

	assign run = (state_q == S_EXEC) && grp_on;

	// multiplier operands
	assign gain_sat = (cfg.echo_gain > 16'd32768) ? fmac_pkg::GAIN_UNITY : {1'b0, cfg.echo_gain};

	always_comb begin
		case (u.asel)
			fmac_pkg::A_GAIN: mac_a = fmac_pkg::COEF_BITS'({1'b0, gain_sat});
			fmac_pkg::A_COS:  mac_a = fmac_pkg::COEF_BITS'(cos_q);
			default:          mac_a = u.coef;
		endcase
		case (u.bsel)
			fmac_pkg::B_X:   mac_b = VB'(x_q) <<< fmac_pkg::SHIFT_IN;
			fmac_pkg::B_PLI: mac_b = VB'(pli_q) <<< fmac_pkg::SHIFT_IN;
			fmac_pkg::B_PLO: mac_b = plo_q;
			fmac_pkg::B_DLI: mac_b = dli_q;
			fmac_pkg::B_DLO: mac_b = dlo_q;
			fmac_pkg::B_Y:   mac_b = y_q;
			fmac_pkg::B_TAP: mac_b = tap;
			default:         mac_b = cur_q;
		endcase
		case (u.addsel)
			fmac_pkg::ADD_HS0: addend = AB'(hs0_q) <<< 22;
			fmac_pkg::ADD_HS1: addend = AB'(hs1_q) <<< 22;
			fmac_pkg::ADD_LS0: addend = AB'(ls0_q) <<< 22;
			fmac_pkg::ADD_LS1: addend = AB'(ls1_q) <<< 22;
			fmac_pkg::ADD_CUR: addend = AB'(cur_q) <<< 15;
			default:           addend = '0;
		endcase
	end

	always_comb begin
		mctl.mul_en = run && (u.kind == fmac_pkg::K_MAC);
		mctl.acc_en = (state_q == S_ACC);
		mctl.clr = u.clr;
		mctl.sh15 = u.sh15;
	end

	fmac_mac u_mac (
		.clk    (clk),
		.ctl    (mctl),
		.a      (mac_a),
		.b      (mac_b),
		.addend (addend),
		.res    (mac_res)
	);

	fmac_echo u_echo (
		.clk    (clk),
		.arst_n (arst_n),
		.clr    (clr.echo),
		.rd_en  (accept),
		.wr_en  (run && (u.kind == fmac_pkg::K_EWR)),
		.delay  (cfg.echo_delay),
		.wdata  (cur_q),
		.tap    (tap)
	);

	// clip and noise
	always_comb begin
		lim = VB'({cfg.dev_limit, {fmac_pkg::SHIFT_IN{1'b0}}});
		if (cur_q > lim)
			clip_v = lim;
		else if (cur_q < -lim)
			clip_v = -lim;
		else
			clip_v = cur_q;
		ndiff = (SB + 1)'(ns_q) - (SB + 1)'(nl_q);
		nsum = (VB + 1)'(cur_q) + ((VB + 1)'(ndiff) <<< fmac_pkg::SHIFT_IN);
		if (nsum > (VB + 1)'(25'sd8388607))
			noise_v = 24'sd8388607;
		else if (nsum < -(VB + 1)'(25'sd8388608))
			noise_v = -24'sd8388608;
		else
			noise_v = nsum[VB-1:0];
	end

	// cosine by quadrant folding
	always_comb begin
		cidx = phase_q[31 -: CB];
		cm = cidx[CB-2] ? (CB - 1)'(fmac_pkg::QUARTER) - {1'b0, cidx[CB-3:0]}
			: {1'b0, cidx[CB-3:0]};
		if (cm == (CB - 1)'(fmac_pkg::QUARTER))
			cval = fmac_pkg::COS_EDGE;
		else
			cval = fmac_pkg::COS_TAB[cm[CB-3:0]];
	end

	// output rounding to the sample format
	always_comb begin
		oround = (VB + 1)'(cur_q) + 25'sd16;
		oshift = (VB - 4)'(oround >>> fmac_pkg::SHIFT_IN);
		if (oshift > 20'sd32767)
			out_v = 16'sh7fff;
		else if (oshift < -20'sd32768)
			out_v = 16'sh8000;
		else
			out_v = oshift[SB-1:0];
	end

	assign out_load = (state_q == S_DONE) && (!out_valid_q || out_ready);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pc_q <= '0;
			pass_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						pc_q <= '0;
						pass_q <= !cfg.enable;
						state_q <= cfg.enable ? S_EXEC : S_DONE;
					end
				end
				S_EXEC: begin
					if (u.kind == fmac_pkg::K_END)
						state_q <= S_DONE;
					else if (run && (u.kind == fmac_pkg::K_MAC))
						state_q <= S_ACC;
					else
						pc_q <= pc_q + 1'b1;
				end
				S_ACC: begin
					pc_q <= pc_q + 1'b1;
					state_q <= S_EXEC;
				end
				S_DONE: begin
					if (out_load)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// input item, cosine, filter output and output sample capture
	always_ff @(posedge clk) begin
		if (accept) begin
			x_q <= sample_in;
			ns_q <= noise_sample;
		end
		if (run && (u.kind == fmac_pkg::K_COS))
			cos_q <= (cidx[CB-1] ^ cidx[CB-2]) ? -cval : cval;
		if (run && (u.kind == fmac_pkg::K_WB) && ((u.dst == fmac_pkg::D_HPY)
				|| (u.dst == fmac_pkg::D_LPY)))
			y_q <= mac_res;
		if (out_load)
			out_q <= pass_q ? x_q : out_v;
	end

	// channel state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pli_q <= '0;
			plo_q <= '0;
			dli_q <= '0;
			dlo_q <= '0;
			hs0_q <= '0;
			hs1_q <= '0;
			ls0_q <= '0;
			ls1_q <= '0;
			nl_q <= '0;
			phase_q <= '0;
			cur_q <= '0;
		end else if (clr.chain) begin
			pli_q <= '0;
			plo_q <= '0;
			dli_q <= '0;
			dlo_q <= '0;
			hs0_q <= '0;
			hs1_q <= '0;
			ls0_q <= '0;
			ls1_q <= '0;
			phase_q <= '0;
		end else if (run) begin
			case (u.kind)
				fmac_pkg::K_WB: begin
					case (u.dst)
						fmac_pkg::D_PRE: begin
							plo_q <= mac_res;
							pli_q <= x_q;
							cur_q <= mac_res;
						end
						fmac_pkg::D_DE: begin
							dli_q <= cur_q;
							dlo_q <= mac_res;
							cur_q <= mac_res;
						end
						fmac_pkg::D_HPN1: hs0_q <= mac_res;
						fmac_pkg::D_HPN2: begin
							hs1_q <= mac_res;
							cur_q <= y_q;
						end
						fmac_pkg::D_LPN1: ls0_q <= mac_res;
						fmac_pkg::D_LPN2: begin
							ls1_q <= mac_res;
							cur_q <= y_q;
						end
						fmac_pkg::D_CUR: cur_q <= mac_res;
						default: ;
					endcase
				end
				fmac_pkg::K_CLIP: cur_q <= clip_v;
				fmac_pkg::K_NOISE: begin
					cur_q <= noise_v;
					nl_q <= ns_q;
				end
				fmac_pkg::K_PHASE: phase_q <= phase_q + cfg.phase_step;
				default: ;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_load)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	`FMAC_ASSERT_NXT(a_busy_after_accept, clk, arst_n, accept, !in_ready, "ready after accept")
	`FMAC_ASSERT_IMP(a_pc_range, clk, arst_n, (state_q == S_EXEC) || (state_q == S_ACC), pc_q <= fmac_pkg::UC_LAST, "pc out of range")
	`FMAC_ASSERT_NXT(a_out_from_done, clk, arst_n, !out_valid_q && (state_q != S_DONE), !out_valid_q, "result without done")
	`FMAC_ASSERT_IMP(a_acc_follows_mac, clk, arst_n, state_q == S_ACC, $past(state_q == S_EXEC), "accumulate without multiply")

endmodule

`default_nettype wire
